// ----- rtl/fcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Fully connected layer package
// Shared widths, command codes, register indexes and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcl_pkg;

    // Field widths of the item channels.
    localparam int CMD_W       = 2;
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 10;
    localparam int DATA_W      = 16;
    localparam int ACC_W       = 32;

    // Configuration port and register widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int N_IN_W     = 11;
    localparam int N_OUT_W    = 7;
    localparam int SHIFT_W    = 5;

    // Width used for column and count comparisons (covers 4096 and 11 bits).
    localparam int CMP_W = 16;

    // Default store sizes.
    localparam int DEF_MAX_INPUTS  = 1024;
    localparam int DEF_MAX_OUTPUTS = 64;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_WEIGHT = 2'd0,
        CMD_WR_BIAS   = 2'd1,
        CMD_ACT       = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_INPUTS   = 2'd0,
        CFG_N_OUTPUTS  = 2'd1,
        CFG_FRAC_SHIFT = 2'd2
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   wr_weight;
        logic                   wr_bias;
        logic                   load_act;
        logic                   mac_issue;
        logic                   emit_rd;
        logic                   emit_ld;
        logic                   last;
        logic [ROW_FIELD_W-1:0] row;
        logic [SHIFT_W-1:0]     frac_shift;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mac_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/fcl_in_if.sv -----
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface fcl_in_if;

    logic                                   valid;
    logic                                   ready;
    logic [fcl_pkg::CMD_W-1:0]              command;
    logic [fcl_pkg::ROW_FIELD_W-1:0]        row;
    logic [fcl_pkg::COL_FIELD_W-1:0]        col;
    logic signed [fcl_pkg::DATA_W-1:0]      data_value;

    modport source (output valid, command, row, col, data_value, input ready);
    modport sink   (input valid, command, row, col, data_value, output ready);

endinterface

// ----- rtl/fcl_out_if.sv -----
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel that carries one row result.
// ----------------------------------------------------------------------------
interface fcl_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [fcl_pkg::DATA_W-1:0]      result_value;
    logic [fcl_pkg::ROW_FIELD_W-1:0]        row_index;
    logic                                   last;

    modport source (output valid, result_value, row_index, last, input ready);
    modport sink   (input valid, result_value, row_index, last, output ready);

endinterface

// ----- rtl/fixed_point_fully_connected_layer_unit.sv -----
// Weight and bias write items are taken in the idle state without starting a sequence.
// For an activation item, one shared multiply-accumulate pipeline updates one row
// accumulator a cycle over all MAX_OUTPUTS rows, then drains the pipeline.
// After the final column each row result is read, then loaded once the output is free.
// Synchronous active-low reset clears the control state, the configuration to its
// defaults and the accumulator valid bits; weight and bias memories are not cleared.
// ----------------------------------------------------------------------------
// Fixed-point fully connected layer
// Matrix-vector product with row bias in 16-bit fixed point, built from a
// controller and a memory-based multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module fixed_point_fully_connected_layer_unit #(
    parameter int MAX_INPUTS  = fcl_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = fcl_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fcl_in_if.sink                          i_in,
    fcl_out_if.source                       o_out
);

    fcl_pkg::t_dp_cmd w_cmd;
    fcl_pkg::t_dp_sts w_sts;

    // Sequencing and item decode.
    fcl_controller #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_command  (i_in.command),
        .i_row      (i_in.row),
        .i_col      (i_in.col),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Stores, multiply-accumulate pipeline and output register.
    fcl_datapath #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_row          (i_in.row),
        .i_col          (i_in.col),
        .i_data         (i_in.data_value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_row_index    (o_out.row_index),
        .o_last         (o_out.last)
    );

endmodule

// ----- rtl/fcl_datapath.sv -----
// ----------------------------------------------------------------------------
// Fully connected layer datapath
// Weight, bias and accumulator memories, the shared multiply-accumulate
// pipeline and the result output register.
// ----------------------------------------------------------------------------
module fcl_datapath #(
    parameter int MAX_INPUTS  = fcl_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = fcl_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcl_pkg::t_dp_cmd                    i_cmd,
    output fcl_pkg::t_dp_sts                    o_sts,
    input  logic [fcl_pkg::ROW_FIELD_W-1:0]     i_row,
    input  logic [fcl_pkg::COL_FIELD_W-1:0]     i_col,
    input  logic signed [fcl_pkg::DATA_W-1:0]   i_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [fcl_pkg::DATA_W-1:0]   o_result_value,
    output logic [fcl_pkg::ROW_FIELD_W-1:0]     o_row_index,
    output logic                                o_last
);

    localparam int ROW_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int COL_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int WDEPTH = MAX_OUTPUTS * (2 ** COL_W);

    // Storage.
    logic signed [fcl_pkg::DATA_W-1:0] r_weight_mem [WDEPTH];
    logic signed [fcl_pkg::DATA_W-1:0] r_bias_mem   [MAX_OUTPUTS];
    logic [fcl_pkg::ACC_W-1:0]         r_acc_mem    [MAX_OUTPUTS];
    logic [MAX_OUTPUTS-1:0]            r_acc_vld;

    // Registered read data.
    logic signed [fcl_pkg::DATA_W-1:0] r_w_rd;
    logic signed [fcl_pkg::DATA_W-1:0] r_b_rd;
    logic [fcl_pkg::ACC_W-1:0]         r_acc_rd;
    logic                              r_acc_rd_vld;

    // Latched activation.
    logic signed [fcl_pkg::DATA_W-1:0] r_act;
    logic [COL_W-1:0]                  r_col_idx;
    logic                              r_clear;

    // Pipeline stages.
    logic                              r_s1_vld;
    logic [ROW_W-1:0]                  r_s1_row;
    logic                              r_s2_vld;
    logic [ROW_W-1:0]                  r_s2_row;
    logic signed [fcl_pkg::ACC_W-1:0]  r_prod;
    logic [fcl_pkg::ACC_W-1:0]         r_base;

    // Output register.
    logic                                r_out_vld;
    logic signed [fcl_pkg::DATA_W-1:0]   r_out_value;
    logic [fcl_pkg::ROW_FIELD_W-1:0]     r_out_row;
    logic                                r_out_last;

    logic [fcl_pkg::CMP_W-1:0]           w_col_ext;
    logic [COL_W-1:0]                    w_in_col;
    logic [ROW_W-1:0]                    w_in_row;
    logic [ROW_W-1:0]                    w_cmd_row;
    logic signed [fcl_pkg::ACC_W-1:0]    w_prod;
    logic [fcl_pkg::ACC_W-1:0]           w_base;
    logic signed [fcl_pkg::ACC_W-1:0]    w_acc_eff;
    logic signed [fcl_pkg::ACC_W-1:0]    w_shifted;
    logic [fcl_pkg::DATA_W-1:0]          w_result;

    // Store addresses taken from the item and the controller's row.
    assign w_col_ext = fcl_pkg::CMP_W'(i_col);
    assign w_in_col  = w_col_ext[COL_W-1:0];
    assign w_in_row  = i_row[ROW_W-1:0];
    assign w_cmd_row = i_cmd.row[ROW_W-1:0];

    // Multiply stage: product and the accumulator value it adds to.
    assign w_prod = fcl_pkg::ACC_W'(r_act) * fcl_pkg::ACC_W'(r_w_rd);
    assign w_base = (r_clear || !r_acc_rd_vld) ? '0 : r_acc_rd;

    // Result: arithmetic shift, cut to 16 bits, add the row bias.
    assign w_acc_eff = r_acc_rd_vld ? $signed(r_acc_rd) : '0;
    assign w_shifted = w_acc_eff >>> i_cmd.frac_shift;
    assign w_result  = w_shifted[fcl_pkg::DATA_W-1:0] + r_b_rd;

    // Weight memory: written from the item, read by the sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight) begin
            r_weight_mem[{w_in_row, w_in_col}] <= i_data;
        end
        if (i_cmd.mac_issue) begin
            r_w_rd <= r_weight_mem[{w_cmd_row, r_col_idx}];
        end
    end

    // Bias memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bias) begin
            r_bias_mem[w_in_row] <= i_data;
        end
        if (i_cmd.emit_rd) begin
            r_b_rd <= r_bias_mem[w_cmd_row];
        end
    end

    // Accumulator memory: one read port for the sweep and the emission,
    // one write port at the end of the pipeline.
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc_mem[r_s2_row] <= r_base + r_prod;
        end
        if (i_cmd.mac_issue || i_cmd.emit_rd) begin
            r_acc_rd <= r_acc_mem[w_cmd_row];
        end
    end

    // Accumulator valid bits: an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld    <= '0;
            r_acc_rd_vld <= 1'b0;
        end else begin
            if (r_s2_vld) begin
                r_acc_vld[r_s2_row] <= 1'b1;
            end
            if (i_cmd.mac_issue || i_cmd.emit_rd) begin
                r_acc_rd_vld <= r_acc_vld[w_cmd_row];
            end
        end
    end

    // Activation latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_act) begin
            r_act     <= i_data;
            r_col_idx <= w_in_col;
            r_clear   <= (i_col == '0);
        end
    end

    // Multiply-accumulate pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.mac_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Multiply-accumulate pipeline data.
    always_ff @(posedge i_clk) begin
        r_s1_row <= w_cmd_row;
        r_s2_row <= r_s1_row;
        r_prod   <= w_prod;
        r_base   <= w_base;
    end

    // Output register: loaded by the controller, freed by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out_value <= w_result;
            r_out_row   <= i_cmd.row;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_sts.mac_busy = r_s1_vld || r_s2_vld;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_value;
    assign o_row_index    = r_out_row;
    assign o_last         = r_out_last;

endmodule

// ----- rtl/fcl_controller.sv -----
// ----------------------------------------------------------------------------
// Fully connected layer controller
// Holds the configuration registers, decodes items and sequences the
// row sweep of each activation and the emission of results.
// ----------------------------------------------------------------------------
module fcl_controller #(
    parameter int MAX_INPUTS  = fcl_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = fcl_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fcl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fcl_pkg::CMD_W-1:0]           i_command,
    input  logic [fcl_pkg::ROW_FIELD_W-1:0]     i_row,
    input  logic [fcl_pkg::COL_FIELD_W-1:0]     i_col,
    output fcl_pkg::t_dp_cmd                    o_cmd,
    input  fcl_pkg::t_dp_sts                    i_sts
);

    localparam logic [fcl_pkg::CMP_W-1:0]   MAX_IN_C   = fcl_pkg::CMP_W'(MAX_INPUTS);
    localparam logic [fcl_pkg::CMP_W-1:0]   MAX_OUT_C  = fcl_pkg::CMP_W'(MAX_OUTPUTS);
    localparam logic [fcl_pkg::N_OUT_W-1:0] LAST_ROW_C = fcl_pkg::N_OUT_W'(MAX_OUTPUTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state                          r_state;
    logic [fcl_pkg::N_OUT_W-1:0]     r_row;
    logic                            r_last_col;
    logic [fcl_pkg::N_IN_W-1:0]      r_n_inputs;
    logic [fcl_pkg::N_OUT_W-1:0]     r_n_outputs;
    logic [fcl_pkg::SHIFT_W-1:0]     r_frac_shift;

    logic [fcl_pkg::CMP_W-1:0]       w_n_in_ext;
    logic [fcl_pkg::CMP_W-1:0]       w_eff_in;
    logic [fcl_pkg::CMP_W-1:0]       w_n_out_ext;
    logic [fcl_pkg::N_OUT_W-1:0]     w_eff_out;
    logic [fcl_pkg::CMP_W-1:0]       w_col_ext;
    logic [fcl_pkg::CMP_W-1:0]       w_row_ext;
    logic                            w_accept;
    logic                            w_act_ok;
    logic                            w_out_last;

    // Effective vector length and row count, clamped to the store sizes, zero taken as one.
    assign w_n_in_ext  = fcl_pkg::CMP_W'(r_n_inputs);
    assign w_eff_in    = (w_n_in_ext == '0) ? fcl_pkg::CMP_W'(1) :
                         (w_n_in_ext > MAX_IN_C) ? MAX_IN_C : w_n_in_ext;
    assign w_n_out_ext = fcl_pkg::CMP_W'(r_n_outputs);
    assign w_eff_out   = (w_n_out_ext == '0) ? fcl_pkg::N_OUT_W'(1) :
                         (w_n_out_ext > MAX_OUT_C) ? fcl_pkg::N_OUT_W'(MAX_OUTPUTS) :
                         r_n_outputs;

    assign w_col_ext  = fcl_pkg::CMP_W'(i_col);
    assign w_row_ext  = fcl_pkg::CMP_W'(i_row);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_act_ok   = (w_col_ext < w_eff_in);
    assign w_out_last = (r_row == w_eff_out - fcl_pkg::N_OUT_W'(1));

    // Datapath commands.
    always_comb begin
        o_cmd            = '0;
        o_cmd.row        = r_row[fcl_pkg::ROW_FIELD_W-1:0];
        o_cmd.frac_shift = r_frac_shift;
        o_cmd.last       = w_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (fcl_pkg::t_cmd'(i_command))
                        fcl_pkg::CMD_WR_WEIGHT: begin
                            o_cmd.wr_weight = (w_col_ext < MAX_IN_C) &&
                                              (w_row_ext < MAX_OUT_C);
                        end
                        fcl_pkg::CMD_WR_BIAS: begin
                            o_cmd.wr_bias = (w_row_ext < MAX_OUT_C);
                        end
                        fcl_pkg::CMD_ACT: begin
                            o_cmd.load_act = w_act_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC:     o_cmd.mac_issue = 1'b1;
            S_EMIT_RD: o_cmd.emit_rd   = 1'b1;
            S_EMIT_LD: o_cmd.emit_ld   = i_sts.out_free;
            default: ;
        endcase
    end

    // State, row counter and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row        <= '0;
            r_last_col   <= 1'b0;
            r_n_inputs   <= fcl_pkg::N_IN_W'(1);
            r_n_outputs  <= fcl_pkg::N_OUT_W'(1);
            r_frac_shift <= '0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (fcl_pkg::t_cfg_idx'(i_cfg_idx))
                    fcl_pkg::CFG_N_INPUTS:   r_n_inputs   <= i_cfg_data[fcl_pkg::N_IN_W-1:0];
                    fcl_pkg::CFG_N_OUTPUTS:  r_n_outputs  <= i_cfg_data[fcl_pkg::N_OUT_W-1:0];
                    fcl_pkg::CFG_FRAC_SHIFT: r_frac_shift <= i_cfg_data[fcl_pkg::SHIFT_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                // Take an item; an activation in range starts a row sweep.
                S_IDLE: begin
                    if (w_accept && (fcl_pkg::t_cmd'(i_command) == fcl_pkg::CMD_ACT) &&
                            w_act_ok) begin
                        r_last_col <= (w_col_ext == w_eff_in - fcl_pkg::CMP_W'(1));
                        r_row      <= '0;
                        r_state    <= S_MAC;
                    end
                end
                // Issue one row a cycle into the multiply-accumulate pipeline.
                S_MAC: begin
                    if (r_row == LAST_ROW_C) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_row <= r_row + fcl_pkg::N_OUT_W'(1);
                    end
                end
                // Let the last accumulator writes land.
                S_DRAIN: begin
                    if (!i_sts.mac_busy) begin
                        r_row   <= '0;
                        r_state <= r_last_col ? S_EMIT_RD : S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                // Load the output register once it is free.
                S_EMIT_LD: begin
                    if (i_sts.out_free) begin
                        if (w_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + fcl_pkg::N_OUT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
